// File: rtl/sfseq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the SPI NOR flash command sequencer.
// No dependencies; used by the interfaces, the top level and the checker.
package sfseq_pkg;

  // configuration port
  localparam int unsigned CFG_W = 16;
  localparam logic CFG_BUSY_TIMEOUT = 1'b0;
  localparam logic CFG_WEL_RETRY    = 1'b1;

  // request opcodes
  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_SECTOR = 3'd2;
  localparam logic [2:0] OP_CHIP   = 3'd3;
  localparam logic [2:0] OP_RX     = 3'd4;
  localparam logic [2:0] OP_HOST   = 3'd5;
  localparam logic [2:0] OP_TICK   = 3'd6;

  // request kinds
  localparam logic [1:0] RK_READ   = 2'd0;
  localparam logic [1:0] RK_WRITE  = 2'd1;
  localparam logic [1:0] RK_SECTOR = 2'd2;
  localparam logic [1:0] RK_CHIP   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_SPI  = 2'd0;
  localparam logic [1:0] KIND_RD   = 2'd1;
  localparam logic [1:0] KIND_WANT = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  // completion status
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_WEL     = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  // flash commands
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_SE    = 8'h20;
  localparam logic [7:0] CMD_CE    = 8'hC7;
  localparam logic [7:0] DUMMY     = 8'hFF;

  // status register bits
  localparam int unsigned SR_BUSY = 0;
  localparam int unsigned SR_WEL  = 1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [23:0] address;
    logic [22:0] length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] spi_byte;
    logic       frame_start;
    logic       frame_end;
    logic [7:0] host_byte;
    logic [2:0] status;
    logic       last;
  } out_item_t;

endpackage

// File: rtl/sfseq_in_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying one input transaction.
// Depends on sfseq_pkg.
interface sfseq_in_if;
  import sfseq_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/sfseq_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one result transaction.
// Depends on sfseq_pkg.
interface sfseq_out_if;
  import sfseq_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/spi_nor_flash_command_sequencer_top.sv
`timescale 1ns / 1ps
// SPI NOR flash command sequencer, top level.
// Depends on sfseq_pkg, sfseq_in_if and sfseq_out_if.

// One request transaction is taken per clock: the sequencer state and all
// results of a transaction are computed in the cycle it is accepted and
// written into a four-entry result queue. Most transactions give one result;
// a received read-data byte gives two (host byte, then the next dummy byte
// or the completion), so sustained throughput is one transaction per cycle
// as long as the result side takes one result per cycle, while the read data
// phase is bound by the result side. The request side is
// ready whenever the result queue holds at most two entries. Every SPI byte
// sent must be answered by a received-byte transaction before the sequence
// moves on; ticks are one-millisecond strobes. PAGE_BYTES must be a power
// of two.
module spi_nor_flash_command_sequencer_top #(
  parameter int unsigned PAGE_BYTES  = 256,
  parameter int unsigned FLASH_BYTES = 4194304
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [sfseq_pkg::CFG_W-1:0] cfg_wdata_i,
  sfseq_in_if.sink                  req_i,
  sfseq_out_if.source               rsp_o
);
  import sfseq_pkg::*;

  localparam int unsigned OW = $clog2(PAGE_BYTES);
  localparam int unsigned CW = $clog2(PAGE_BYTES + 1);
  localparam logic [24:0] FlashEnd = 25'(FLASH_BYTES);
  localparam logic [CW-1:0] PageSize = CW'(PAGE_BYTES);

  // sequencer phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_WEN_CMD   = 4'd1;
  localparam logic [3:0] PH_WEN_RDSR  = 4'd2;
  localparam logic [3:0] PH_WEN_STAT  = 4'd3;
  localparam logic [3:0] PH_WEN_WAIT  = 4'd4;
  localparam logic [3:0] PH_HDR       = 4'd5;
  localparam logic [3:0] PH_RD_DATA   = 4'd6;
  localparam logic [3:0] PH_WR_NEED   = 4'd7;
  localparam logic [3:0] PH_WR_DATA   = 4'd8;
  localparam logic [3:0] PH_POLL_CMD  = 4'd9;
  localparam logic [3:0] PH_POLL_STAT = 4'd10;
  localparam logic [3:0] PH_POLL_WAIT = 4'd11;

  function automatic out_item_t spi_res(logic [7:0] b, logic fs, logic fe);
    out_item_t r;
    r = '0;
    r.kind = KIND_SPI;
    r.spi_byte = b;
    r.frame_start = fs;
    r.frame_end = fe;
    return r;
  endfunction

  function automatic out_item_t done_res(logic [2:0] st);
    out_item_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.status = st;
    return r;
  endfunction

  function automatic out_item_t host_res(logic [7:0] d);
    out_item_t r;
    r = '0;
    r.kind = KIND_RD;
    r.host_byte = d;
    return r;
  endfunction

  function automatic out_item_t want_res();
    out_item_t r;
    r = '0;
    r.kind = KIND_WANT;
    return r;
  endfunction

  function automatic logic [7:0] header_cmd(logic [1:0] rk);
    logic [7:0] c;
    unique case (rk)
      RK_READ:  c = CMD_READ;
      RK_WRITE: c = CMD_PP;
      RK_SECTOR: c = CMD_SE;
      default:  c = CMD_CE;
    endcase
    return c;
  endfunction

  // configuration registers
  logic [15:0] busy_timeout_q;
  logic [3:0]  wel_limit_q;

  // sequencer state
  logic [3:0]    phase_q, phase_d;
  logic [1:0]    rkind_q, rkind_d;
  logic [23:0]   addr_q, addr_d;
  logic [22:0]   bytes_q, bytes_d;
  logic [CW-1:0] chunk_q, chunk_d;
  logic [1:0]    hdr_q, hdr_d;
  logic [3:0]    retry_q, retry_d;
  logic [15:0]   poll_q, poll_d;

  // result queue
  out_item_t fifo_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;

  logic      accept;
  logic      pop;
  out_item_t res0, res1;
  logic [1:0] nres;

  // chunk size for a new page chunk
  logic [23:0]   ck_addr;
  logic [22:0]   ck_bytes;
  logic [CW-1:0] ck_room;
  logic [CW-1:0] ck_size;

  assign accept = req_i.valid && req_i.ready;
  assign pop    = rsp_o.valid && rsp_o.ready;
  assign req_i.ready   = (cnt_q <= 3'd2);
  assign rsp_o.valid   = (cnt_q != 3'd0);
  assign rsp_o.payload = fifo_q[rptr_q];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_timeout_q <= 16'd500;
      wel_limit_q    <= 4'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BUSY_TIMEOUT: busy_timeout_q <= cfg_wdata_i[15:0];
        CFG_WEL_RETRY:    wel_limit_q    <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // first chunk of a write comes from the request, later ones from state
  always_comb begin
    if (phase_q == PH_IDLE) begin
      ck_addr  = req_i.payload.address;
      ck_bytes = req_i.payload.length;
    end else begin
      ck_addr  = addr_q;
      ck_bytes = bytes_q;
    end
    ck_room = PageSize - CW'(ck_addr[OW-1:0]);
    if (23'(ck_room) > ck_bytes) begin
      ck_size = CW'(ck_bytes);
    end else begin
      ck_size = ck_room;
    end
  end

  // next state and results of one transaction
  always_comb begin
    logic [1:0]  hdr_n;
    logic [7:0]  hbyte;
    logic [22:0] bytes_n;
    logic [15:0] poll_n;
    logic [24:0] end_addr;

    phase_d = phase_q;
    rkind_d = rkind_q;
    addr_d  = addr_q;
    bytes_d = bytes_q;
    chunk_d = chunk_q;
    hdr_d   = hdr_q;
    retry_d = retry_q;
    poll_d  = poll_q;
    res0 = '0;
    res1 = '0;
    nres = 2'd0;
    hdr_n = hdr_q + 2'd1;
    bytes_n = bytes_q - 23'(bytes_q != '0);
    poll_n = poll_q + 16'd1;
    end_addr = {1'b0, req_i.payload.address} + {2'b0, req_i.payload.length};
    unique case (hdr_n)
      2'd1:    hbyte = addr_q[23:16];
      2'd2:    hbyte = addr_q[15:8];
      default: hbyte = addr_q[7:0];
    endcase

    if (accept) begin
      priority if (req_i.payload.opcode <= OP_CHIP) begin
        nres = 2'd1;
        if (phase_q != PH_IDLE) begin
          res0 = done_res(ST_TIMEOUT);
        end else begin
          rkind_d = req_i.payload.opcode[1:0];
          addr_d  = req_i.payload.address;
          bytes_d = '0;
          chunk_d = '0;
          hdr_d   = '0;
          retry_d = '0;
          poll_d  = '0;
          if (req_i.payload.opcode == OP_SECTOR || req_i.payload.opcode == OP_CHIP) begin
            res0 = spi_res(CMD_WREN, 1'b1, 1'b1);
            phase_d = PH_WEN_CMD;
          end else if (req_i.payload.length == '0) begin
            res0 = done_res(ST_INVALID);
          end else if (end_addr > FlashEnd) begin
            res0 = done_res(ST_RANGE);
          end else begin
            bytes_d = req_i.payload.length;
            if (req_i.payload.opcode == OP_READ) begin
              res0 = spi_res(CMD_READ, 1'b1, 1'b0);
              phase_d = PH_HDR;
            end else begin
              chunk_d = ck_size;
              res0 = spi_res(CMD_WREN, 1'b1, 1'b1);
              phase_d = PH_WEN_CMD;
            end
          end
        end
      end else if (req_i.payload.opcode == OP_RX) begin
        unique case (phase_q)
          PH_WEN_CMD: begin
            nres = 2'd1;
            res0 = spi_res(CMD_RDSR, 1'b1, 1'b0);
            phase_d = PH_WEN_RDSR;
          end
          PH_WEN_RDSR: begin
            nres = 2'd1;
            res0 = spi_res(DUMMY, 1'b0, 1'b1);
            phase_d = PH_WEN_STAT;
          end
          PH_WEN_STAT: begin
            if (req_i.payload.data_byte[SR_WEL]) begin
              // write enable latched: start the command header
              nres = 2'd1;
              phase_d = PH_HDR;
              res0 = spi_res(header_cmd(rkind_q), 1'b1, rkind_q == RK_CHIP);
              hdr_d = (rkind_q == RK_CHIP) ? 2'd3 : 2'd0;
            end else begin
              retry_d = retry_q + 4'd1;
              phase_d = PH_WEN_WAIT;
            end
          end
          PH_HDR: begin
            nres = 2'd1;
            if (hdr_q != 2'd3) begin
              hdr_d = hdr_n;
              res0 = spi_res(hbyte, 1'b0, hdr_n == 2'd3 && rkind_q == RK_SECTOR);
            end else if (rkind_q == RK_READ) begin
              res0 = spi_res(DUMMY, 1'b0, bytes_q == 23'd1);
              phase_d = PH_RD_DATA;
            end else if (rkind_q == RK_WRITE) begin
              res0 = want_res();
              phase_d = PH_WR_NEED;
            end else begin
              poll_d = '0;
              res0 = spi_res(CMD_RDSR, 1'b1, 1'b0);
              phase_d = PH_POLL_CMD;
            end
          end
          PH_RD_DATA: begin
            nres = 2'd2;
            res0 = host_res(req_i.payload.data_byte);
            bytes_d = bytes_n;
            addr_d = addr_q + 24'd1;
            if (bytes_n != '0) begin
              res1 = spi_res(DUMMY, 1'b0, bytes_n == 23'd1);
            end else begin
              res1 = done_res(ST_OK);
              phase_d = PH_IDLE;
            end
          end
          PH_WR_DATA: begin
            nres = 2'd1;
            if (chunk_q != '0) begin
              res0 = want_res();
              phase_d = PH_WR_NEED;
            end else begin
              poll_d = '0;
              res0 = spi_res(CMD_RDSR, 1'b1, 1'b0);
              phase_d = PH_POLL_CMD;
            end
          end
          PH_POLL_CMD: begin
            nres = 2'd1;
            res0 = spi_res(DUMMY, 1'b0, 1'b1);
            phase_d = PH_POLL_STAT;
          end
          PH_POLL_STAT: begin
            if (!req_i.payload.data_byte[SR_BUSY]) begin
              nres = 2'd1;
              if (rkind_q == RK_WRITE && bytes_q != '0) begin
                // next page chunk
                chunk_d = ck_size;
                retry_d = '0;
                res0 = spi_res(CMD_WREN, 1'b1, 1'b1);
                phase_d = PH_WEN_CMD;
              end else begin
                res0 = done_res(ST_OK);
                phase_d = PH_IDLE;
              end
            end else begin
              phase_d = PH_POLL_WAIT;
            end
          end
          default: ;
        endcase
      end else if (req_i.payload.opcode == OP_HOST) begin
        if (phase_q == PH_WR_NEED) begin
          nres = 2'd1;
          res0 = spi_res(req_i.payload.data_byte, 1'b0, chunk_q == CW'(1));
          chunk_d = chunk_q - CW'(chunk_q != '0);
          bytes_d = bytes_n;
          addr_d = addr_q + 24'd1;
          phase_d = PH_WR_DATA;
        end
      end else if (req_i.payload.opcode == OP_TICK) begin
        if (phase_q == PH_WEN_WAIT) begin
          nres = 2'd1;
          if (retry_q >= wel_limit_q) begin
            res0 = done_res(ST_WEL);
            phase_d = PH_IDLE;
          end else begin
            res0 = spi_res(CMD_WREN, 1'b1, 1'b1);
            phase_d = PH_WEN_CMD;
          end
        end else if (phase_q == PH_POLL_WAIT) begin
          nres = 2'd1;
          poll_d = poll_n;
          if (poll_n >= busy_timeout_q) begin
            res0 = done_res(ST_TIMEOUT);
            phase_d = PH_IDLE;
          end else begin
            res0 = spi_res(CMD_RDSR, 1'b1, 1'b0);
            phase_d = PH_POLL_CMD;
          end
        end
      end else begin
        nres = 2'd0;
      end
    end

    // mark the final result of this transaction
    if (nres == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  // sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rkind_q <= '0;
      addr_q  <= '0;
      bytes_q <= '0;
      chunk_q <= '0;
      hdr_q   <= '0;
      retry_q <= '0;
      poll_q  <= '0;
    end else begin
      phase_q <= phase_d;
      rkind_q <= rkind_d;
      addr_q  <= addr_d;
      bytes_q <= bytes_d;
      chunk_q <= chunk_d;
      hdr_q   <= hdr_d;
      retry_q <= retry_d;
      poll_q  <= poll_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (nres != 2'd0) begin
      fifo_q[wptr_q] <= res0;
    end
    if (nres == 2'd2) begin
      fifo_q[wptr_q + 2'd1] <= res1;
    end
  end

  // result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + nres;
      rptr_q <= rptr_q + 2'(pop);
      cnt_q  <= cnt_q + 3'(nres) - 3'(pop);
    end
  end

endmodule

// File: rtl/sfseq_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the sequencer result channel, bound to the top level.
// Depends on sfseq_pkg and sfseq_out_if.
module sfseq_chk (
  input logic         clk_i,
  input logic         rst_ni,
  sfseq_out_if.source rsp
);
  import sfseq_pkg::*;

  // a stalled result transaction holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
    else $error("result changed while stalled");

  // framing fields only on spi bytes
  a_spi_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.payload.kind != KIND_SPI |->
      rsp.payload.spi_byte == 8'h00 && !rsp.payload.frame_start && !rsp.payload.frame_end)
    else $error("framing fields set on non-spi result");

  // status only on completions, host data only on read bytes
  a_side_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |->
      (rsp.payload.kind == KIND_DONE || rsp.payload.status == ST_OK) &&
      (rsp.payload.kind == KIND_RD || rsp.payload.host_byte == 8'h00))
    else $error("status or host byte on wrong result kind");

  // a frame always opens with a flash command
  a_frame_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.payload.frame_start |->
      rsp.payload.spi_byte == CMD_WREN || rsp.payload.spi_byte == CMD_RDSR ||
      rsp.payload.spi_byte == CMD_PP || rsp.payload.spi_byte == CMD_READ ||
      rsp.payload.spi_byte == CMD_SE || rsp.payload.spi_byte == CMD_CE)
    else $error("frame opened with a non-command byte");

endmodule

bind spi_nor_flash_command_sequencer_top sfseq_chk u_sfseq_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .rsp    (rsp_o)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SPI NOR flash command sequencer top level.
// Depends on sfseq_pkg, sfseq_in_if, sfseq_out_if and the sequencer RTL.
module testbench;
  import sfseq_pkg::*;

  localparam int unsigned PAGE_BYTES      = 256;
  localparam int unsigned FLASH_BYTES     = 4194304;
  localparam int unsigned HALF_PERIOD     = 5;
  localparam int unsigned ADDR_BYTES      = 3;
  localparam logic [23:0] ADDR_MAX        = 24'hFFFFFF;
  localparam logic [22:0] LEN_MAX         = 23'h7FFFFF;
  localparam logic [2:0]  OP_UNUSED       = 3'd7;
  localparam logic [15:0] BUSY_TICKS_RESET = 16'd500;
  localparam logic [3:0]  WEL_TRIES_RESET = 4'd3;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned DRAIN_LIMIT     = 4000;
  localparam int unsigned TAIL_CYCLES     = 10;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned MAX_MISS_LINES  = 40;

  // sequencer states as seen by the predictor
  typedef enum logic [4:0] {
    S_IDLE, S_WREN_ACK, S_RDSR_ACK, S_WEL_CHECK, S_WEL_WAIT, S_HEADER,
    S_READ_DATA, S_WANT_HOST, S_WRITE_ACK, S_POLL_ACK, S_BUSY_CHECK, S_BUSY_WAIT
  } seq_state_e;

  // predicts the frames and completions of each transaction and checks the results
  class flash_seq_scoreboard;
    seq_state_e  seq_state;
    logic [1:0]  req_kind;
    logic [23:0] cur_addr;
    logic [22:0] bytes_left;
    logic [8:0]  page_left;
    logic [2:0]  hdr_idx;
    logic [3:0]  wel_tries;
    logic [15:0] busy_polls;
    logic [15:0] busy_limit;
    logic [3:0]  wel_limit;
    out_item_t   burst[$];
    out_item_t   pending_results[$];
    int unsigned miss_count;
    int unsigned results_checked;
    int unsigned done_seen[5];

    function new();
      seq_state       = S_IDLE;
      req_kind        = RK_READ;
      cur_addr        = '0;
      bytes_left      = '0;
      page_left       = '0;
      hdr_idx         = '0;
      wel_tries       = '0;
      busy_polls      = '0;
      busy_limit      = BUSY_TICKS_RESET;
      wel_limit       = WEL_TRIES_RESET;
      miss_count      = 0;
      results_checked = 0;
      foreach (done_seen[i]) done_seen[i] = 0;
    endfunction

    function void set_limit(logic idx, logic [CFG_W-1:0] value);
      if (idx == CFG_BUSY_TIMEOUT) busy_limit = value;
      else wel_limit = value[3:0];
    endfunction

    function void push_result(logic [1:0] kind, logic [7:0] spi, logic fs, logic fe,
                              logic [7:0] hb, logic [2:0] st);
      out_item_t r;
      r.kind        = kind;
      r.spi_byte    = spi;
      r.frame_start = fs;
      r.frame_end   = fe;
      r.host_byte   = hb;
      r.status      = st;
      r.last        = 1'b0;
      burst.push_back(r);
    endfunction

    function void spi_out(logic [7:0] b, logic fs, logic fe);
      push_result(KIND_SPI, b, fs, fe, 8'h00, ST_OK);
    endfunction

    function void complete(logic [2:0] st);
      push_result(KIND_DONE, 8'h00, 1'b0, 1'b0, 8'h00, st);
      seq_state = S_IDLE;
    endfunction

    function void start_wren();
      wel_tries = '0;
      spi_out(CMD_WREN, 1'b1, 1'b1);
      seq_state = S_WREN_ACK;
    endfunction

    // next program chunk stops at the page boundary
    function void begin_page();
      int unsigned room;
      room = PAGE_BYTES - (cur_addr % PAGE_BYTES);
      if (room > bytes_left) room = bytes_left;
      page_left = 9'(room);
      start_wren();
    endfunction

    function void start_poll();
      busy_polls = '0;
      spi_out(CMD_RDSR, 1'b1, 1'b0);
      seq_state = S_POLL_ACK;
    endfunction

    function void send_command();
      hdr_idx   = '0;
      seq_state = S_HEADER;
      case (req_kind)
        RK_CHIP: begin
          spi_out(CMD_CE, 1'b1, 1'b1);
          hdr_idx = 3'(ADDR_BYTES);
        end
        RK_READ:  spi_out(CMD_READ, 1'b1, 1'b0);
        RK_WRITE: spi_out(CMD_PP, 1'b1, 1'b0);
        default:  spi_out(CMD_SE, 1'b1, 1'b0);
      endcase
    endfunction

    function void after_header();
      if (req_kind == RK_READ) begin
        spi_out(DUMMY, 1'b0, bytes_left == 1);
        seq_state = S_READ_DATA;
      end else if (req_kind == RK_WRITE) begin
        push_result(KIND_WANT, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK);
        seq_state = S_WANT_HOST;
      end else begin
        start_poll();
      end
    endfunction

    function void on_request(logic [2:0] op, logic [23:0] addr, logic [22:0] len);
      int unsigned span;
      // a request while busy is refused and the running one goes on
      if (seq_state != S_IDLE) begin
        push_result(KIND_DONE, 8'h00, 1'b0, 1'b0, 8'h00, ST_TIMEOUT);
        return;
      end
      req_kind   = op[1:0];
      cur_addr   = addr;
      bytes_left = '0;
      page_left  = '0;
      hdr_idx    = '0;
      wel_tries  = '0;
      busy_polls = '0;
      if (op == OP_READ || op == OP_WRITE) begin
        span = addr;
        span += len;
        if (len == 0) begin
          push_result(KIND_DONE, 8'h00, 1'b0, 1'b0, 8'h00, ST_INVALID);
          return;
        end
        if (span > FLASH_BYTES) begin
          push_result(KIND_DONE, 8'h00, 1'b0, 1'b0, 8'h00, ST_RANGE);
          return;
        end
        bytes_left = len;
        if (op == OP_READ) send_command();
        else begin_page();
      end else begin
        start_wren();
      end
    endfunction

    // byte shifted in from the flash; returns 0 when nothing waits for it
    function bit on_flash_byte(logic [7:0] d);
      case (seq_state)
        S_WREN_ACK: begin
          spi_out(CMD_RDSR, 1'b1, 1'b0);
          seq_state = S_RDSR_ACK;
        end
        S_RDSR_ACK: begin
          spi_out(DUMMY, 1'b0, 1'b1);
          seq_state = S_WEL_CHECK;
        end
        S_WEL_CHECK: begin
          if (d[SR_WEL]) begin
            send_command();
          end else begin
            wel_tries++;
            seq_state = S_WEL_WAIT;
          end
        end
        S_HEADER: begin
          if (hdr_idx < ADDR_BYTES) begin
            hdr_idx++;
            spi_out(8'(cur_addr >> (8 * (ADDR_BYTES - hdr_idx))), 1'b0,
                    hdr_idx == ADDR_BYTES && req_kind == RK_SECTOR);
          end else begin
            after_header();
          end
        end
        S_READ_DATA: begin
          push_result(KIND_RD, 8'h00, 1'b0, 1'b0, d, ST_OK);
          if (bytes_left > 0) bytes_left--;
          cur_addr++;
          if (bytes_left > 0) spi_out(DUMMY, 1'b0, bytes_left == 1);
          else complete(ST_OK);
        end
        S_WRITE_ACK: begin
          if (page_left > 0) begin
            push_result(KIND_WANT, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK);
            seq_state = S_WANT_HOST;
          end else begin
            start_poll();
          end
        end
        S_POLL_ACK: begin
          spi_out(DUMMY, 1'b0, 1'b1);
          seq_state = S_BUSY_CHECK;
        end
        S_BUSY_CHECK: begin
          if (!d[SR_BUSY]) begin
            if (req_kind == RK_WRITE && bytes_left > 0) begin_page();
            else complete(ST_OK);
          end else begin
            seq_state = S_BUSY_WAIT;
          end
        end
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // one-millisecond tick: retry write enable or poll busy again
    function bit on_tick();
      if (seq_state == S_WEL_WAIT) begin
        if (wel_tries >= wel_limit) begin
          complete(ST_WEL);
        end else begin
          spi_out(CMD_WREN, 1'b1, 1'b1);
          seq_state = S_WREN_ACK;
        end
      end else if (seq_state == S_BUSY_WAIT) begin
        busy_polls++;
        if (busy_polls >= busy_limit) begin
          complete(ST_TIMEOUT);
        end else begin
          spi_out(CMD_RDSR, 1'b1, 1'b0);
          seq_state = S_POLL_ACK;
        end
      end else begin
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // accepted input transaction; returns 0 when the sequencer ignores it
    function bit take_item(in_item_t it);
      bit        acted;
      out_item_t r;
      acted = 1'b1;
      burst.delete();
      case (it.opcode)
        OP_READ, OP_WRITE, OP_SECTOR, OP_CHIP:
          on_request(it.opcode, it.address, it.length);
        OP_RX:   acted = on_flash_byte(it.data_byte);
        OP_TICK: acted = on_tick();
        OP_HOST: begin
          if (seq_state == S_WANT_HOST) begin
            spi_out(it.data_byte, 1'b0, page_left == 1);
            if (page_left > 0) page_left--;
            if (bytes_left > 0) bytes_left--;
            cur_addr++;
            seq_state = S_WRITE_ACK;
          end else begin
            acted = 1'b0;
          end
        end
        default: acted = 1'b0;
      endcase
      if (burst.size() > 0) begin
        r = burst.pop_back();
        r.last = 1'b1;
        burst.push_back(r);
      end
      foreach (burst[i]) pending_results.push_back(burst[i]);
      return acted;
    endfunction

    task report_miss(string what);
      miss_count++;
      if (miss_count <= MAX_MISS_LINES)
        $display("%0t: result %0d mismatch: %s", $time, results_checked, what);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_miss($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        report_miss($sformatf("result of kind %0d with nothing expected", got.kind));
      end else begin
        want = pending_results.pop_front();
        if (want.kind == KIND_DONE) done_seen[want.status]++;
        compare_field("kind", got.kind, want.kind);
        compare_field("spi_byte", got.spi_byte, want.spi_byte);
        compare_field("frame_start", got.frame_start, want.frame_start);
        compare_field("frame_end", got.frame_end, want.frame_end);
        compare_field("host_byte", got.host_byte, want.host_byte);
        compare_field("status", got.status, want.status);
        compare_field("last", got.last, want.last);
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  sfseq_in_if          req_if ();
  sfseq_out_if         rsp_if ();

  flash_seq_scoreboard sb;
  int unsigned         req_idle_pct;
  int unsigned         rsp_idle_pct;
  bit                  hold_results;
  int unsigned         items_sent;
  int unsigned         items_acted;
  int unsigned         cycle_count;

  spi_nor_flash_command_sequencer_top #(
    .PAGE_BYTES (PAGE_BYTES),
    .FLASH_BYTES(FLASH_BYTES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // clock
  always #HALF_PERIOD clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic in_item_t make_item(logic [2:0] op, logic [23:0] addr,
                                         logic [22:0] len, logic [7:0] d);
    return '{opcode: op, address: addr, length: len, data_byte: d};
  endfunction

  // picks what the host or the flash does next, given the predicted state
  function automatic in_item_t next_item(bit noisy);
    in_item_t    it;
    int unsigned pick;
    int unsigned len;
    it.opcode    = OP_RX;
    it.address   = 24'($urandom());
    it.length    = 23'($urandom());
    it.data_byte = 8'($urandom());
    pick         = $urandom_range(0, 99);
    // stray transaction: request while busy, or a byte, tick or undefined opcode nobody waits for
    if (noisy && pick < 6) begin
      if (sb.seq_state == S_IDLE) it.opcode = 3'($urandom_range(OP_RX, OP_UNUSED));
      else it.opcode = 3'($urandom_range(OP_READ, OP_UNUSED));
      return it;
    end
    case (sb.seq_state)
      S_IDLE: begin
        if (pick < 25) begin
          it.opcode  = OP_READ;
          len        = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(1, 6);
          it.length  = 23'(len);
          it.address = ($urandom_range(0, 5) == 0) ? 24'(FLASH_BYTES - len)
                                                   : 24'($urandom_range(0, FLASH_BYTES - 64));
        end else if (pick < 55) begin
          it.opcode = OP_WRITE;
          len       = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 24)
                                                  : $urandom_range(1, 5);
          it.length = 23'(len);
          case ($urandom_range(0, 3))
            0: it.address = 24'(FLASH_BYTES - len);
            1: it.address = 24'($urandom_range(0, FLASH_BYTES / PAGE_BYTES - 1) * PAGE_BYTES
                                + PAGE_BYTES - $urandom_range(1, 8));
            default: it.address = 24'($urandom_range(0, FLASH_BYTES - 64));
          endcase
        end else if (pick < 70) begin
          it.opcode = OP_SECTOR;
          if ($urandom_range(0, 3) == 0) it.address = $urandom_range(0, 1) ? ADDR_MAX : '0;
        end else if (pick < 80) begin
          it.opcode = OP_CHIP;
        end else if (pick < 88) begin
          it.opcode = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
          it.length = '0;
        end else begin
          it.opcode = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
          if ($urandom_range(0, 1)) begin
            it.address = 24'($urandom_range(FLASH_BYTES, ADDR_MAX));
          end else begin
            it.address = 24'($urandom_range(0, FLASH_BYTES - 1));
            it.length  = 23'(FLASH_BYTES - it.address + $urandom_range(1, FLASH_BYTES - 1));
          end
        end
      end
      S_WEL_CHECK:  it.data_byte[SR_WEL]  = ($urandom_range(0, 3) != 0);
      S_BUSY_CHECK: it.data_byte[SR_BUSY] = ($urandom_range(0, 9) < 4);
      S_WEL_WAIT, S_BUSY_WAIT: it.opcode = OP_TICK;
      S_WANT_HOST: it.opcode = OP_HOST;
      default: ;
    endcase
    return it;
  endfunction

  // offer one transaction and hold it until the sequencer takes it
  task automatic drive(input in_item_t it);
    if (!hold_results && $urandom_range(0, 99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk_i);
    end
    req_if.payload <= it;
    req_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
    items_acted += sb.take_item(it);
  endtask

  task automatic finish_request();
    while (sb.seq_state != S_IDLE) drive(next_item(1'b0));
  endtask

  // wait until every expected result has come, then for the pipeline to settle
  task automatic settle();
    int unsigned waited;
    waited = 0;
    req_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_limit(idx, value);
  endtask

  // one configuration setting followed by random request sequences
  task automatic run_phase(input logic [15:0] busy_ticks, input logic [3:0] wel_tries,
                           input int unsigned req_pct, input int unsigned rsp_pct,
                           input int unsigned quota, input bit squeeze);
    write_reg(CFG_BUSY_TIMEOUT, busy_ticks);
    write_reg(CFG_WEL_RETRY, {12'd0, wel_tries});
    cfg_we_i     <= 1'b0;
    req_idle_pct = req_pct;
    rsp_idle_pct = rsp_pct;
    if (squeeze) hold_results = 1'b1;
    quota += items_acted;
    while (items_acted < quota || sb.seq_state != S_IDLE) drive(next_item(1'b1));
    settle();
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
        rsp_if.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
        rsp_if.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
  end

  // watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // reset, directed cases, then random phases over the register settings
  initial begin : stimulus
    sb             = new();
    req_idle_pct   = 20;
    rsp_idle_pct   = 20;
    hold_results   = 1'b0;
    items_sent     = 0;
    items_acted    = 0;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_BUSY_TIMEOUT;
    cfg_wdata_i    <= '0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // argument checks, with zero length taking priority over range
    drive(make_item(OP_READ, 24'h123456, '0, 8'h00));
    drive(make_item(OP_WRITE, ADDR_MAX, '0, 8'hFF));
    drive(make_item(OP_READ, ADDR_MAX, LEN_MAX, 8'h00));
    drive(make_item(OP_WRITE, 24'(FLASH_BYTES - 1), 23'd2, 8'hA5));
    // undefined opcode and strays while idle
    drive(make_item(OP_UNUSED, ADDR_MAX, LEN_MAX, 8'hFF));
    drive(make_item(OP_TICK, '0, '0, 8'h00));
    drive(make_item(OP_RX, '0, '0, 8'hFF));
    drive(make_item(OP_HOST, '0, '0, 8'h5A));
    // last byte of the flash, with a request arriving while busy
    drive(make_item(OP_READ, 24'(FLASH_BYTES - 1), 23'd1, 8'h00));
    drive(make_item(OP_SECTOR, '0, '0, 8'h00));
    finish_request();
    drive(make_item(OP_CHIP, ADDR_MAX, LEN_MAX, 8'hFF));
    finish_request();
    settle();

    // smallest limits with a long result hold-off
    run_phase(16'd1, 4'd1, 25, 25, 15, 1'b1);
    // largest limits, no idling on either side
    run_phase(16'hFFFF, 4'd15, 0, 0, 15, 1'b0);
    // zero limits behave as one
    run_phase(16'd0, 4'd0, 30, 30, 10, 1'b0);
    // small random limits
    run_phase(16'($urandom_range(2, 6)), 4'($urandom_range(2, 5)), 20, 20, 15, 1'b0);

    if (sb.pending_results.size() != 0)
      sb.report_miss($sformatf("%0d expected results never arrived",
                               sb.pending_results.size()));
    $display("sent %0d transactions (%0d acted on), checked %0d results",
             items_sent, items_acted, sb.results_checked);
    $display("completions ok/invalid/range/wel/timeout: %0d/%0d/%0d/%0d/%0d",
             sb.done_seen[ST_OK], sb.done_seen[ST_INVALID], sb.done_seen[ST_RANGE],
             sb.done_seen[ST_WEL], sb.done_seen[ST_TIMEOUT]);
    if (sb.miss_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sfseq_pkg.sv
rtl/sfseq_in_if.sv
rtl/sfseq_out_if.sv
rtl/spi_nor_flash_command_sequencer_top.sv
rtl/sfseq_chk.sv
dv/testbench.sv
